/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PWTT_ASSERT_IMPLIES(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PWTT_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* src/pwtt_pkg.sv */
// Types and constants of the pulse width telegram transmitter.
`default_nettype none

package pwtt_pkg;

    localparam int TICK_W      = 16;
    localparam int PHASE_W     = 3;
    localparam int PKT_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // Phase codes as shown on the result channel
    localparam logic [PHASE_W-1:0] PHASE_DECIDE  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_PRE_HI  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_PRE_LO  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_ONE_HI  = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_ONE_LO  = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_ZERO_HI = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_ZERO_LO = 3'd6;
    localparam logic [PHASE_W-1:0] PHASE_PAUSE   = 3'd7;

    typedef enum logic [7:0] {
        ST_DECIDE  = 8'b0000_0001,
        ST_PRE_HI  = 8'b0000_0010,
        ST_PRE_LO  = 8'b0000_0100,
        ST_ONE_HI  = 8'b0000_1000,
        ST_ONE_LO  = 8'b0001_0000,
        ST_ZERO_HI = 8'b0010_0000,
        ST_ZERO_LO = 8'b0100_0000,
        ST_PAUSE   = 8'b1000_0000
    } phase_state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PACKET_WORDS   = 3'd0,
        REG_PRE_HIGH_TICKS = 3'd1,
        REG_PRE_LOW_TICKS  = 3'd2,
        REG_ONE_HIGH_TICKS = 3'd3,
        REG_ONE_LOW_TICKS  = 3'd4,
        REG_ZERO_HIGH_TICKS = 3'd5,
        REG_ZERO_LOW_TICKS = 3'd6,
        REG_PAUSE_TICKS    = 3'd7
    } cfg_reg_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_state_t st);
        logic [PHASE_W-1:0] code;
        case (st)
            ST_DECIDE:  code = PHASE_DECIDE;
            ST_PRE_HI:  code = PHASE_PRE_HI;
            ST_PRE_LO:  code = PHASE_PRE_LO;
            ST_ONE_HI:  code = PHASE_ONE_HI;
            ST_ONE_LO:  code = PHASE_ONE_LO;
            ST_ZERO_HI: code = PHASE_ZERO_HI;
            ST_ZERO_LO: code = PHASE_ZERO_LO;
            ST_PAUSE:   code = PHASE_PAUSE;
            default:    code = PHASE_DECIDE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* src/pwtt_ifs.sv */
// Channel interfaces: tick input, result output and register writes.
`default_nettype none

interface pwtt_step_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink (input valid, input advance, output ready);
    modport monitor (input valid, input ready, input advance);
endinterface

interface pwtt_report_if import pwtt_pkg::*;;
    logic               valid;
    logic               ready;
    logic               line_level;
    logic [PHASE_W-1:0] phase;
    logic [PKT_W-1:0]   packet_index;

    modport source (output valid, output line_level, output phase, output packet_index,
                    input ready);
    modport sink (input valid, input line_level, input phase, input packet_index,
                  output ready);
    modport monitor (input valid, input ready, input line_level, input phase,
                     input packet_index);
endinterface

interface pwtt_cfg_if import pwtt_pkg::*; #(
    parameter int DATA_W = 48
);
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
    modport monitor (input valid, input ready, input index, input data);
endinterface

`default_nettype wire

/* src/pulse_width_telegram_transmitter.sv */
// Pulse width telegram transmitter: tick-driven serial line encoder.
//
// step carries one beat per timer tick; advance = 1 lets one tick elapse,
// advance = 0 only asks for a report of the current state. Every accepted
// step beat yields exactly one report beat: line level, phase code and the
// packet being sent, all as they stand after that tick.
// cfg writes the eight timing/packet registers (index 0 packet words,
// 1..7 tick counts); it is always ready and is meant to be used while idle.
// The report beat comes in the cycle after its step beat. One step beat can be
// taken every cycle: the next state is computed in one pass from the state
// registers and lands in the report register together with the new state.
// step.ready is low only while a report beat waits and report.ready is low,
// so a stalled receiver holds the report and backs up the tick source.
// Reset: all timings 1, packet words 0, phase decide, packet PACKETS-1
// selected with the preamble next, line low, no report pending.
`default_nettype none

module pulse_width_telegram_transmitter import pwtt_pkg::*; #(
    parameter int PACKETS         = 3,
    parameter int BITS_PER_PACKET = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pwtt_step_if.sink     step,
    pwtt_report_if.source report,
    pwtt_cfg_if.sink      cfg
);

    localparam int WORD_W  = PACKETS * BITS_PER_PACKET;
    localparam int STORE_W = (WORD_W > CFG_DATA_W) ? CFG_DATA_W : WORD_W;
    localparam int POS_W   = $clog2(WORD_W) + 1;
    localparam int BP_W    = $clog2(BITS_PER_PACKET + 1);

    localparam logic [BP_W-1:0]   BP_FULL = BP_W'(BITS_PER_PACKET);
    localparam logic [BP_W-1:0]   BP_LAST = BP_W'(BITS_PER_PACKET - 1);
    localparam logic [PKT_W-1:0]  PKT_TOP = PKT_W'(PACKETS - 1);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // configuration
    logic [STORE_W-1:0] words_reg;
    logic [TICK_W-1:0]  pre_hi_reg, pre_lo_reg, one_hi_reg, one_lo_reg;
    logic [TICK_W-1:0]  zero_hi_reg, zero_lo_reg, pause_reg;

    // sequencer state
    phase_state_t      phase_reg, phase_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [TICK_W-1:0] tick_target_reg, tick_target_next;
    logic [BP_W-1:0]   bit_pos_reg, bit_pos_next;
    logic              packet_done_reg, packet_done_next;
    logic [PKT_W-1:0]  packet_sel_reg, packet_sel_next;
    logic              line_reg, line_next;

    // report register
    logic               res_valid_reg;
    logic               res_line_reg;
    logic [PHASE_W-1:0] res_phase_reg;
    logic [PKT_W-1:0]   res_pkt_reg;

    logic               step_accept;
    logic [TICK_W-1:0]  cnt_inc;
    logic               done;
    logic [POS_W-1:0]   pos;
    logic [STORE_W-1:0] shifted;
    logic               cur_bit;

    assign step.ready  = !res_valid_reg || report.ready;
    assign step_accept = step.valid && step.ready;
    assign cfg.ready   = 1'b1;

    assign report.valid        = res_valid_reg;
    assign report.line_level   = res_line_reg;
    assign report.phase        = res_phase_reg;
    assign report.packet_index = res_pkt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg   <= '0;
            pre_hi_reg  <= TICK_W'(1);
            pre_lo_reg  <= TICK_W'(1);
            one_hi_reg  <= TICK_W'(1);
            one_lo_reg  <= TICK_W'(1);
            zero_hi_reg <= TICK_W'(1);
            zero_lo_reg <= TICK_W'(1);
            pause_reg   <= TICK_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_PACKET_WORDS:    words_reg   <= cfg.data[STORE_W-1:0];
                REG_PRE_HIGH_TICKS:  pre_hi_reg  <= cfg.data[TICK_W-1:0];
                REG_PRE_LOW_TICKS:   pre_lo_reg  <= cfg.data[TICK_W-1:0];
                REG_ONE_HIGH_TICKS:  one_hi_reg  <= cfg.data[TICK_W-1:0];
                REG_ONE_LOW_TICKS:   one_lo_reg  <= cfg.data[TICK_W-1:0];
                REG_ZERO_HIGH_TICKS: zero_hi_reg <= cfg.data[TICK_W-1:0];
                REG_ZERO_LOW_TICKS:  zero_lo_reg <= cfg.data[TICK_W-1:0];
                REG_PAUSE_TICKS:     pause_reg   <= cfg.data[TICK_W-1:0];
                default:             ;
            endcase
        end
    end

    // bit of the selected packet at the current position; past the stored word reads 0
    assign pos     = POS_W'(packet_sel_reg) * POS_W'(BITS_PER_PACKET) + POS_W'(bit_pos_reg);
    assign shifted = words_reg >> pos;
    assign cur_bit = (pos < POS_W'(STORE_W)) && shifted[0];

    assign cnt_inc = (tick_count_reg != TICK_MAX) ? tick_count_reg + 1'b1 : tick_count_reg;
    assign done    = cnt_inc >= tick_target_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        tick_target_next = tick_target_reg;
        bit_pos_next     = bit_pos_reg;
        packet_done_next = packet_done_reg;
        packet_sel_next  = packet_sel_reg;
        line_next        = line_reg;

        if (step_accept && step.advance)
        begin
            tick_count_next = cnt_inc;
            case (phase_reg)
                ST_DECIDE:
                begin
                    tick_count_next = '0;
                    if (packet_done_reg)
                    begin
                        packet_sel_next  = (packet_sel_reg == '0) ? PKT_TOP
                                                                  : packet_sel_reg - 1'b1;
                        bit_pos_next     = BP_FULL;
                        packet_done_next = 1'b0;
                        phase_next       = ST_PAUSE;
                        tick_target_next = pause_reg;
                    end
                    else if (bit_pos_reg >= BP_FULL)
                    begin
                        phase_next       = ST_PRE_HI;
                        tick_target_next = pre_hi_reg;
                    end
                    else if (cur_bit)
                    begin
                        phase_next       = ST_ONE_HI;
                        tick_target_next = one_hi_reg;
                    end
                    else
                    begin
                        phase_next       = ST_ZERO_HI;
                        tick_target_next = zero_hi_reg;
                    end
                end
                ST_PAUSE:
                begin
                    line_next = 1'b0;
                    if (done)
                        phase_next = ST_DECIDE;
                end
                ST_PRE_HI:
                begin
                    line_next = 1'b1;
                    if (done)
                    begin
                        phase_next       = ST_PRE_LO;
                        tick_count_next  = '0;
                        tick_target_next = pre_lo_reg;
                    end
                end
                ST_PRE_LO:
                begin
                    line_next = 1'b0;
                    if (done)
                    begin
                        bit_pos_next = BP_LAST;
                        phase_next   = ST_DECIDE;
                    end
                end
                ST_ONE_HI:
                begin
                    line_next = 1'b1;
                    if (done)
                    begin
                        phase_next       = ST_ONE_LO;
                        tick_count_next  = '0;
                        tick_target_next = one_lo_reg;
                    end
                end
                ST_ZERO_HI:
                begin
                    line_next = 1'b1;
                    if (done)
                    begin
                        phase_next       = ST_ZERO_LO;
                        tick_count_next  = '0;
                        tick_target_next = zero_lo_reg;
                    end
                end
                ST_ONE_LO, ST_ZERO_LO:
                begin
                    line_next = 1'b0;
                    if (done)
                    begin
                        if (bit_pos_reg == '0)
                            packet_done_next = 1'b1;
                        else
                            bit_pos_next = bit_pos_reg - 1'b1;
                        phase_next = ST_DECIDE;
                    end
                end
                default:
                    phase_next = ST_DECIDE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ST_DECIDE;
            tick_count_reg  <= '0;
            tick_target_reg <= '0;
            bit_pos_reg     <= BP_FULL;
            packet_done_reg <= 1'b0;
            packet_sel_reg  <= PKT_TOP;
            line_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            tick_target_reg <= tick_target_next;
            bit_pos_reg     <= bit_pos_next;
            packet_done_reg <= packet_done_next;
            packet_sel_reg  <= packet_sel_next;
            line_reg        <= line_next;
            if (step_accept)
                res_valid_reg <= 1'b1;
            else if (report.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // report payload: state after the tick of the accepted beat
    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            res_line_reg  <= line_next;
            res_phase_reg <= phase_code(phase_next);
            res_pkt_reg   <= packet_sel_next;
        end
    end

endmodule

`default_nettype wire

/* src/pwtt_checker.sv */
// Port-level checks of the pulse width telegram transmitter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pwtt_checker import pwtt_pkg::*; #(
    parameter int PACKETS = 3
) (
    input logic               clk,
    input logic               rst_n,
    input logic               step_valid,
    input logic               step_ready,
    input logic               report_valid,
    input logic               report_ready,
    input logic               line_level,
    input logic [PHASE_W-1:0] phase,
    input logic [PKT_W-1:0]   packet_index
);

    localparam logic [PKT_W-1:0] PKT_TOP = PKT_W'(PACKETS - 1);

    logic                     step_beat;
    logic                     report_wait;
    logic                     report_free;
    logic                     pkt_ok;
    logic                     idle_report;
    logic [PHASE_W+PKT_W+1:0] report_beat;

    assign step_beat   = step_valid && step_ready;
    assign report_wait = report_valid && !report_ready;
    assign report_free = !report_valid || report_ready;
    assign pkt_ok      = packet_index <= PKT_TOP;
    assign idle_report = report_valid && (phase == PHASE_DECIDE || phase == PHASE_PAUSE);
    assign report_beat = {report_valid, line_level, phase, packet_index};

    // a waiting report beat keeps its payload
    `PWTT_ASSERT_NEXT(a_report_hold, report_wait, $stable(report_beat), "beat moved in stall")

    // no step beat is taken while a report beat is stuck
    `PWTT_ASSERT_IMPLIES(a_no_overrun, step_beat, report_free, "step taken in stall")

    // every step beat gives a report beat in the next cycle
    `PWTT_ASSERT_NEXT(a_report_follows, step_beat, report_valid, "no report after step beat")

    `PWTT_ASSERT_IMPLIES(a_pkt_range, report_valid, pkt_ok, "packet index out of range")

    // decide and pause always sit on a low line
    `PWTT_ASSERT_IMPLIES(a_idle_low, idle_report, !line_level, "line high in decide or pause")

endmodule

bind pulse_width_telegram_transmitter pwtt_checker #(
    .PACKETS (PACKETS)
) u_pwtt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_valid   (step.valid),
    .step_ready   (step.ready),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .line_level   (report.line_level),
    .phase        (report.phase),
    .packet_index (report.packet_index)
);

`default_nettype wire

/* sim/tb_pulse_width_telegram_transmitter.sv */
// Testbench for the pulse width telegram transmitter: predicted line reports, random ticks.
`default_nettype none

module tb_pulse_width_telegram_transmitter;
    import pwtt_pkg::*;

    localparam int NUM_PACKETS = 3;
    localparam int PACKET_BITS = 16;
    localparam int CFG_W       = 48;
    localparam int STALL_LIMIT = 5000;

    typedef enum int {
        TIMING_LOWEST,
        TIMING_HIGHEST,
        TIMING_RANDOM
    } timing_profile_t;

    typedef struct packed {
        logic               line_level;
        logic [PHASE_W-1:0] phase;
        logic [PKT_W-1:0]   packet_index;
    } line_report_t;

    // Tracks the transmitter state and checks each report beat in order.
    class line_report_scoreboard;
        logic [CFG_W-1:0]   packet_words;
        logic [TICK_W-1:0]  pre_high, pre_low, one_high, one_low, zero_high, zero_low;
        logic [TICK_W-1:0]  pause_len;
        logic [PHASE_W-1:0] phase;
        logic [TICK_W-1:0]  tick_count;
        logic [TICK_W-1:0]  tick_target;
        int                 bit_pos;
        bit                 packet_done;
        logic [PKT_W-1:0]   packet_sel;
        logic               line;
        line_report_t       expected_reports[$];
        int                 errors;

        function new();
            packet_words = '0;
            pre_high     = TICK_W'(1);
            pre_low      = TICK_W'(1);
            one_high     = TICK_W'(1);
            one_low      = TICK_W'(1);
            zero_high    = TICK_W'(1);
            zero_low     = TICK_W'(1);
            pause_len    = TICK_W'(1);
            phase        = PHASE_DECIDE;
            tick_count   = '0;
            tick_target  = '0;
            bit_pos      = PACKET_BITS;
            packet_done  = 1'b0;
            packet_sel   = PKT_W'(NUM_PACKETS - 1);
            line         = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
            case (r)
                REG_PACKET_WORDS:    packet_words = d;
                REG_PRE_HIGH_TICKS:  pre_high     = d[TICK_W-1:0];
                REG_PRE_LOW_TICKS:   pre_low      = d[TICK_W-1:0];
                REG_ONE_HIGH_TICKS:  one_high     = d[TICK_W-1:0];
                REG_ONE_LOW_TICKS:   one_low      = d[TICK_W-1:0];
                REG_ZERO_HIGH_TICKS: zero_high    = d[TICK_W-1:0];
                REG_ZERO_LOW_TICKS:  zero_low     = d[TICK_W-1:0];
                REG_PAUSE_TICKS:     pause_len    = d[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void enter(logic [PHASE_W-1:0] ph, logic [TICK_W-1:0] target);
            phase       = ph;
            tick_count  = '0;
            tick_target = target;
        endfunction

        function void note_tick(logic advance);
            bit           done;
            line_report_t exp_rep;
            if (advance)
            begin
                if (tick_count != '1)
                    tick_count++;
                done = (tick_count >= tick_target);
                case (phase)
                    PHASE_DECIDE:
                    begin
                        if (packet_done)
                        begin
                            packet_sel  = (packet_sel == '0) ? PKT_W'(NUM_PACKETS - 1)
                                                             : packet_sel - 1'b1;
                            bit_pos     = PACKET_BITS;
                            packet_done = 1'b0;
                            enter(PHASE_PAUSE, pause_len);
                        end
                        else if (bit_pos >= PACKET_BITS)
                            enter(PHASE_PRE_HI, pre_high);
                        else if (packet_words[packet_sel * PACKET_BITS + bit_pos])
                            enter(PHASE_ONE_HI, one_high);
                        else
                            enter(PHASE_ZERO_HI, zero_high);
                    end
                    PHASE_PAUSE:
                    begin
                        line = 1'b0;
                        if (done)
                            phase = PHASE_DECIDE;
                    end
                    PHASE_PRE_HI:
                    begin
                        line = 1'b1;
                        if (done)
                            enter(PHASE_PRE_LO, pre_low);
                    end
                    PHASE_PRE_LO:
                    begin
                        line = 1'b0;
                        if (done)
                        begin
                            bit_pos = PACKET_BITS - 1;
                            phase   = PHASE_DECIDE;
                        end
                    end
                    PHASE_ONE_HI:
                    begin
                        line = 1'b1;
                        if (done)
                            enter(PHASE_ONE_LO, one_low);
                    end
                    PHASE_ZERO_HI:
                    begin
                        line = 1'b1;
                        if (done)
                            enter(PHASE_ZERO_LO, zero_low);
                    end
                    PHASE_ONE_LO, PHASE_ZERO_LO:
                    begin
                        line = 1'b0;
                        if (done)
                        begin
                            if (bit_pos == 0)
                                packet_done = 1'b1;
                            else
                                bit_pos--;
                            phase = PHASE_DECIDE;
                        end
                    end
                    default: phase = PHASE_DECIDE;
                endcase
            end
            exp_rep.line_level   = line;
            exp_rep.phase        = phase;
            exp_rep.packet_index = packet_sel;
            expected_reports.push_back(exp_rep);
        endfunction

        function void check_report(logic got_line, logic [PHASE_W-1:0] got_phase,
                                   logic [PKT_W-1:0] got_pkt);
            line_report_t exp_rep;
            if (expected_reports.size() == 0)
            begin
                $error("report beat with no tick waiting for it");
                errors++;
                return;
            end
            exp_rep = expected_reports.pop_front();
            if (got_line !== exp_rep.line_level)
            begin
                $error("line_level: expected %0d, got %0d", exp_rep.line_level, got_line);
                errors++;
            end
            if (got_phase !== exp_rep.phase)
            begin
                $error("phase: expected %0d, got %0d", exp_rep.phase, got_phase);
                errors++;
            end
            if (got_pkt !== exp_rep.packet_index)
            begin
                $error("packet_index: expected %0d, got %0d", exp_rep.packet_index, got_pkt);
                errors++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pwtt_step_if                   step_ch ();
    pwtt_report_if                 report_ch ();
    pwtt_cfg_if #(.DATA_W(CFG_W))  cfg_ch ();

    pulse_width_telegram_transmitter #(
        .PACKETS         (NUM_PACKETS),
        .BITS_PER_PACKET (PACKET_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step_ch),
        .report (report_ch),
        .cfg    (cfg_ch)
    );

    line_report_scoreboard sb;
    int                    send_idle_pct;
    int                    stall_pct;
    int                    quiet_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver backpressure
    always @(negedge clk)
        report_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (report_ch.valid && report_ch.ready)
                sb.check_report(report_ch.line_level, report_ch.phase, report_ch.packet_index);
            if (step_ch.valid && step_ch.ready)
                sb.note_tick(step_ch.advance);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);

            if ((report_ch.valid && report_ch.ready) || (step_ch.valid && step_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // advance is 0 with probability hold_pct
    task automatic send_ticks(input int n, input int hold_pct);
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                step_ch.valid <= 1'b0;
                @(negedge clk);
            end
            step_ch.valid   <= 1'b1;
            step_ch.advance <= ($urandom_range(0, 99) >= hold_pct);
            @(posedge clk);
            while (!step_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        step_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] reg_value(cfg_reg_t r, timing_profile_t prof);
        logic [CFG_W-1:0]  v;
        logic [TICK_W-1:0] ticks;
        v[47:32] = 16'($urandom);
        v[31:0]  = $urandom;
        if (r == REG_PACKET_WORDS)
        begin
            if (prof == TIMING_LOWEST)
                v = '1;
        end
        else
        begin
            case (prof)
                TIMING_LOWEST:  ticks = '0;
                TIMING_HIGHEST: ticks = '1;
                default:
                    ticks = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom_range(0, 40))
                                                        : TICK_W'($urandom_range(0, 4));
            endcase
            // upper bits stay random: only the low 16 bits count
            v[TICK_W-1:0] = ticks;
        end
        return v;
    endfunction

    task automatic configure(input timing_profile_t prof);
        cfg_reg_t r;
        wait_drained();
        r = r.first();
        do
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= r;
            cfg_ch.data  <= reg_value(r, prof);
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
            r = r.next();
        end
        while (r != r.first());
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        timing_profile_t prof;
        sb              = new();
        quiet_cycles    = 0;
        send_idle_pct   = 20;
        stall_pct       = 78;
        rst_n           = 1'b0;
        step_ch.valid   = 1'b0;
        step_ch.advance = 1'b0;
        report_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_PACKET_WORDS;
        cfg_ch.data     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: hold first, then walk into the preamble of all-zero packets
        send_ticks(3, 100);
        send_ticks(6, 0);
        // zero tick counts, all-ones packets
        configure(TIMING_LOWEST);
        send_ticks(12, 0);
        send_ticks(2, 100);

        for (int mode = 0; mode < 3; mode++)
        begin
            wait_drained();
            send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 78 : 0;
            stall_pct     = (mode == 0) ? 78 : (mode == 1) ? 20 : 0;
            for (int round = 0; round < 3; round++)
            begin
                if (mode == 2 && round == 2)
                    prof = TIMING_HIGHEST;
                else if (mode == 1 && round == 0)
                    prof = TIMING_LOWEST;
                else
                    prof = TIMING_RANDOM;
                configure(prof);
                send_ticks(78, 12);
            end
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected reports never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* pulse_width_telegram_transmitter.f */
+incdir+src
src/pwtt_pkg.sv
src/pwtt_ifs.sv
src/pulse_width_telegram_transmitter.sv
src/pwtt_checker.sv
sim/tb_pulse_width_telegram_transmitter.sv
